### sv/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the CRC byte update for the frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

	// input item opcodes
	localparam logic OP_START   = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	// configuration register indexes
	localparam int CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] REG_SOF_FIRST   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SOF_SECOND  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_FRAME_LIMIT = 2'd2;

	localparam logic [7:0]  SofFirstReset   = 8'hAA;
	localparam logic [7:0]  SofSecondReset  = 8'h55;
	localparam logic [15:0] FrameLimitReset = 16'd64;

	// CRC-16/CCITT-FALSE
	localparam logic [15:0] CrcPoly = 16'h1021;
	localparam logic [15:0] CrcInit = 16'hFFFF;

	// header (5) plus CRC (2)
	localparam logic [16:0] FrameOverhead = 17'd7;

	// command queue between front and back
	localparam int CmdDepth = 4;
	localparam int CmdPtrW  = $clog2(CmdDepth);
	localparam int CmdCntW  = $clog2(CmdDepth + 1);

	typedef enum logic [1:0] {
		CMD_REJECT,
		CMD_HEADER,
		CMD_DATA
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;   // type byte or payload byte
		logic [15:0] len;    // payload length, header only
		logic        last;   // CRC follows this command
	} cmd_t;

	// one byte through the CRC, MSB first
	function automatic logic [15:0] crc8_update(input logic [15:0] crc_in,
			input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### sv/crc16_frame_builder.sv
// ----------------------------------------------------------------------------
// crc16_frame_builder
// Byte-stream framer: header, payload pass-through, CRC-16/CCITT-FALSE trailer.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ----------------   ------------------------------------------
//  input     push / full        op, pkt_type, body_len, data_byte
//  result    empty / pop        frame_byte, end_of_frame, rejected
//  config    cfg_we             cfg_idx, cfg_wdata
//
//  One input item is accepted per cycle while the 4-entry command queue has
//  room. The byte sequencer emits one frame byte per cycle while the output
//  register is free or popped: a payload byte or rejection gives one result,
//  the last payload byte adds the CRC, and a header gives SOF, type and length
//  bytes (and the CRC for an empty frame). The output register is refilled
//  in the same cycle it is popped if a command is waiting. Reset clears the
//  open-frame tracking, queue, output valid flag; restores register defaults.
//
module crc16_frame_builder (
	input  logic                         clk,
	input  logic                         arst_n,
	// input items
	input  logic                         push,
	output logic                         full,
	input  logic                         op,
	input  logic [7:0]                   pkt_type,
	input  logic [15:0]                  body_len,
	input  logic [7:0]                   data_byte,
	// result items
	output logic                         empty,
	input  logic                         pop,
	output logic [7:0]                   frame_byte,
	output logic                         end_of_frame,
	output logic                         rejected,
	// configuration
	input  logic                         cfg_we,
	input  logic [cfb_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [15:0]                  cfg_wdata
);

	logic [7:0]    sof_first_q;
	logic [7:0]    sof_second_q;
	logic [15:0]   frame_limit_q;

	logic          accept;
	logic          cmd_push;
	cfb_pkg::cmd_t cmd_in;
	cfb_pkg::cmd_t cmd_head;
	logic          cmd_empty;
	logic          cmd_pop;

	// configuration registers; indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_first_q   <= cfb_pkg::SofFirstReset;
			sof_second_q  <= cfb_pkg::SofSecondReset;
			frame_limit_q <= cfb_pkg::FrameLimitReset;
		end else if (cfg_we) begin
			case (cfg_idx)
				cfb_pkg::REG_SOF_FIRST:   sof_first_q   <= cfg_wdata[7:0];
				cfb_pkg::REG_SOF_SECOND:  sof_second_q  <= cfg_wdata[7:0];
				cfb_pkg::REG_FRAME_LIMIT: frame_limit_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// full comes straight from the command queue; dropped payload items are
	// still accepted but never reach it
	assign accept = push && !full;

	cfb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (op),
		.pkt_type    (pkt_type),
		.body_len    (body_len),
		.data_byte   (data_byte),
		.frame_limit (frame_limit_q),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	cfb_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_cmd  (cmd_in),
		.rd_en   (cmd_pop),
		.rd_cmd  (cmd_head),
		.q_empty (cmd_empty),
		.q_full  (full)
	);

	// sof bytes must only change while idle (the block does not enforce it); the back end reads them live
	cfb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_head),
		.cmd_valid    (!cmd_empty),
		.sof_first    (sof_first_q),
		.sof_second   (sof_second_q),
		.pop          (pop),
		.cmd_pop      (cmd_pop),
		.frame_byte   (frame_byte),
		.end_of_frame (end_of_frame),
		.rejected     (rejected),
		.empty        (empty)
	);

	// a rejection result always closes the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rejected) |-> end_of_frame)
		else $error("rejection without end_of_frame");

	// a full queue must hold work for the back end
	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !cmd_empty)
		else $error("queue full but empty");

	// a result only appears after the back end had a command
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && $past(empty)) |-> $past(!cmd_empty))
		else $error("result appeared without a command");

	// the queue releases a command only when it holds one
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command popped from an empty queue");

endmodule

### sv/cfb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// cfb_cmd_fifo
// Small command queue that decouples the classifier from the byte sequencer.
// ----------------------------------------------------------------------------
module cfb_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  cfb_pkg::cmd_t wr_cmd,
	input  logic          rd_en,
	output cfb_pkg::cmd_t rd_cmd,
	output logic          q_empty,
	output logic          q_full
);

	cfb_pkg::cmd_t                    mem_q [cfb_pkg::CmdDepth];
	logic [cfb_pkg::CmdPtrW-1:0]      wr_ptr_q;
	logic [cfb_pkg::CmdPtrW-1:0]      rd_ptr_q;
	logic [cfb_pkg::CmdCntW-1:0]      count_q;
	logic                             do_wr;
	logic                             do_rd;

	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == cfb_pkg::CmdCntW'(cfb_pkg::CmdDepth));
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == cfb_pkg::CmdPtrW'(cfb_pkg::CmdDepth - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == cfb_pkg::CmdPtrW'(cfb_pkg::CmdDepth - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/cfb_front.sv
// ----------------------------------------------------------------------------
// cfb_front
// Classifies accepted items into commands and tracks the open frame.
// ----------------------------------------------------------------------------
module cfb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          op,
	input  logic [7:0]    pkt_type,
	input  logic [15:0]   body_len,
	input  logic [7:0]    data_byte,
	input  logic [15:0]   frame_limit,
	output logic          cmd_push,
	output cfb_pkg::cmd_t cmd
);

	logic        in_frame_q;
	logic [15:0] remain_q;
	logic        in_frame_d;
	logic [15:0] remain_d;
	logic [16:0] total;
	logic        oversize;

	// length sum kept at 17 bits so it never wraps
	assign total    = {1'b0, body_len} + cfb_pkg::FrameOverhead;
	assign oversize = total > {1'b0, frame_limit};

	always_comb begin
		cmd_push   = 1'b0;
		cmd.kind   = cfb_pkg::CMD_DATA;
		cmd.data   = data_byte;
		cmd.len    = body_len;
		cmd.last   = 1'b0;
		in_frame_d = in_frame_q;
		remain_d   = remain_q;
		if (accept) begin
			if (op == cfb_pkg::OP_START) begin
				cmd_push = 1'b1;
				if (oversize) begin
					cmd.kind   = cfb_pkg::CMD_REJECT;
					in_frame_d = 1'b0;
					remain_d   = '0;
				end else begin
					cmd.kind   = cfb_pkg::CMD_HEADER;
					cmd.data   = pkt_type;
					cmd.last   = (body_len == '0);
					in_frame_d = (body_len != '0);
					remain_d   = body_len;
				end
			end else if (in_frame_q) begin
				// payload byte; dropped when no frame is open
				cmd_push = 1'b1;
				cmd.last = (remain_q == 16'd1);
				remain_d = remain_q - 1'b1;
				if (remain_q == 16'd1) begin
					in_frame_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			remain_q   <= '0;
		end else begin
			in_frame_q <= in_frame_d;
			remain_q   <= remain_d;
		end
	end

endmodule

### sv/cfb_back.sv
// ----------------------------------------------------------------------------
// cfb_back
// Byte sequencer: expands commands into frame bytes, runs the CRC and holds
// the output register.
// ----------------------------------------------------------------------------
module cfb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  cfb_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	input  logic [7:0]    sof_first,
	input  logic [7:0]    sof_second,
	input  logic          pop,
	output logic          cmd_pop,
	output logic [7:0]    frame_byte,
	output logic          end_of_frame,
	output logic          rejected,
	output logic          empty
);

	// header steps
	localparam logic [2:0] HSTEP_SOF1   = 3'd0;
	localparam logic [2:0] HSTEP_SOF2   = 3'd1;
	localparam logic [2:0] HSTEP_TYPE   = 3'd2;
	localparam logic [2:0] HSTEP_LEN_LO = 3'd3;
	localparam logic [2:0] HSTEP_LEN_HI = 3'd4;
	localparam logic [2:0] HSTEP_CRC_LO = 3'd5;
	localparam logic [2:0] HSTEP_CRC_HI = 3'd6;
	// payload steps
	localparam logic [2:0] DSTEP_BYTE   = 3'd0;
	localparam logic [2:0] DSTEP_CRC_LO = 3'd1;
	localparam logic [2:0] DSTEP_CRC_HI = 3'd2;

	logic [2:0]  step_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        eof_q;
	logic        rej_q;

	logic        emit;
	logic [7:0]  byte_sel;
	logic        eof_sel;
	logic        rej_sel;
	logic        crc_upd;
	logic        last_step;
	logic [15:0] crc_base;
	logic [15:0] crc_next;

	assign emit    = cmd_valid && (!out_valid_q || pop);
	assign cmd_pop = emit && last_step;

	always_comb begin
		byte_sel  = '0;
		eof_sel   = 1'b0;
		rej_sel   = 1'b0;
		crc_upd   = 1'b0;
		last_step = 1'b0;
		case (cmd.kind)
			cfb_pkg::CMD_REJECT: begin
				eof_sel   = 1'b1;
				rej_sel   = 1'b1;
				last_step = 1'b1;
			end
			cfb_pkg::CMD_HEADER: begin
				case (step_q)
					HSTEP_SOF1: begin
						byte_sel = sof_first;
						crc_upd  = 1'b1;
					end
					HSTEP_SOF2: begin
						byte_sel = sof_second;
						crc_upd  = 1'b1;
					end
					HSTEP_TYPE: begin
						byte_sel = cmd.data;
						crc_upd  = 1'b1;
					end
					HSTEP_LEN_LO: begin
						byte_sel = cmd.len[7:0];
						crc_upd  = 1'b1;
					end
					HSTEP_LEN_HI: begin
						byte_sel  = cmd.len[15:8];
						crc_upd   = 1'b1;
						last_step = !cmd.last;
					end
					HSTEP_CRC_LO: begin
						byte_sel = crc_q[7:0];
					end
					HSTEP_CRC_HI: begin
						byte_sel  = crc_q[15:8];
						eof_sel   = 1'b1;
						last_step = 1'b1;
					end
					default: begin
						last_step = 1'b1;
					end
				endcase
			end
			cfb_pkg::CMD_DATA: begin
				case (step_q)
					DSTEP_BYTE: begin
						byte_sel  = cmd.data;
						crc_upd   = 1'b1;
						last_step = !cmd.last;
					end
					DSTEP_CRC_LO: begin
						byte_sel = crc_q[7:0];
					end
					DSTEP_CRC_HI: begin
						byte_sel  = crc_q[15:8];
						eof_sel   = 1'b1;
						last_step = 1'b1;
					end
					default: begin
						last_step = 1'b1;
					end
				endcase
			end
			default: begin
				last_step = 1'b1;
			end
		endcase
	end

	// the first header byte restarts the CRC
	assign crc_base = (cmd.kind == cfb_pkg::CMD_HEADER && step_q == HSTEP_SOF1) ?
		cfb_pkg::CrcInit : crc_q;
	assign crc_next = cfb_pkg::crc8_update(crc_base, byte_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			crc_q       <= cfb_pkg::CrcInit;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				step_q      <= last_step ? '0 : step_q + 1'b1;
				out_valid_q <= 1'b1;
				if (crc_upd) begin
					crc_q <= crc_next;
				end else if (cmd.kind == cfb_pkg::CMD_REJECT) begin
					crc_q <= cfb_pkg::CrcInit;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= byte_sel;
			eof_q  <= eof_sel;
			rej_q  <= rej_sel;
		end
	end

	assign empty        = !out_valid_q;
	assign frame_byte   = byte_q;
	assign end_of_frame = eof_q;
	assign rejected     = rej_q;

endmodule
